@@ design/assert_macros.svh @@
// Assertion macros shared by the SD card start-up sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SDI_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("sequencer check failed");

`define SDI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequencer check failed");

`define SDI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`else

`define SDI_ASSERT_ALWAYS(label, clk, rst, expr)

`define SDI_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define SDI_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ design/sdinit_pkg.sv @@
// Types, constants and command helpers for the SD card SPI start-up sequencer.
package sdinit_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DUMMY,
    PH_CMD,
    PH_WAIT,
    PH_DATA,
    PH_RELEASE,
    PH_DONE
  } phase_t;

  localparam logic [2:0] RC_RUN       = 3'd0;
  localparam logic [2:0] RC_OK        = 3'd1;
  localparam logic [2:0] RC_NO_CARD   = 3'd2;
  localparam logic [2:0] RC_V1_CARD   = 3'd3;
  localparam logic [2:0] RC_ECHO      = 3'd4;
  localparam logic [2:0] RC_TIMEOUT   = 3'd5;
  localparam logic [2:0] RC_NOT_READY = 3'd6;

  localparam logic [2:0] STEP_CMD0   = 3'd0;
  localparam logic [2:0] STEP_CMD8   = 3'd1;
  localparam logic [2:0] STEP_CMD55  = 3'd2;
  localparam logic [2:0] STEP_ACMD41 = 3'd3;
  localparam logic [2:0] STEP_CMD58  = 3'd4;
  localparam logic [2:0] STEP_CMD16  = 3'd5;

  localparam logic [2:0] REG_DUMMY_BYTE_COUNT   = 3'd0;
  localparam logic [2:0] REG_RESPONSE_TRIES     = 3'd1;
  localparam logic [2:0] REG_INIT_TRY_LIMIT     = 3'd2;
  localparam logic [2:0] REG_VOLTAGE_CODE       = 3'd3;
  localparam logic [2:0] REG_CHECK_PATTERN      = 3'd4;
  localparam logic [2:0] REG_HOST_CAPACITY_BYTE = 3'd5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [7:0]  RST_DUMMY_BYTE_COUNT   = 8'd74;
  localparam logic [7:0]  RST_RESPONSE_TRIES     = 8'd8;
  localparam logic [15:0] RST_INIT_TRY_LIMIT     = 16'hFFFF;
  localparam logic [3:0]  RST_VOLTAGE_CODE       = 4'd1;
  localparam logic [7:0]  RST_CHECK_PATTERN      = 8'hAA;
  localparam logic [7:0]  RST_HOST_CAPACITY_BYTE = 8'h40;

  localparam logic [7:0] IDLE_BYTE      = 8'hFF;
  localparam logic [7:0] CMD_START_BITS = 8'h40;
  localparam logic [7:0] CMD16_ARG_BYTE = 8'h02;
  localparam logic [7:0] R1_IDLE_VALUE  = 8'h01;
  localparam logic [6:0] CRC7_POLY      = 7'h09;

  localparam int R1_IDLE_BIT    = 0;
  localparam int R1_ILLEGAL_BIT = 2;
  localparam int R1_BUSY_BIT    = 7;
  localparam int OCR_READY_BIT  = 7;
  localparam int OCR_CCS_BIT    = 6;

  localparam logic [7:0] CMD_CRC_POS   = 8'd5;
  localparam logic [7:0] CMD_LENGTH    = 8'd6;
  localparam logic [7:0] DATA_LENGTH   = 8'd4;
  localparam logic [1:0] DATA_FIRST    = 2'd0;
  localparam logic [1:0] DATA_LAST     = 2'd3;
  localparam logic [7:0] ARG_POS_ONE   = 8'd1;
  localparam logic [7:0] ARG_POS_THREE = 8'd3;
  localparam logic [7:0] ARG_POS_FOUR  = 8'd4;

  typedef struct packed {
    logic [7:0]  dummy_byte_count;
    logic [7:0]  response_tries;
    logic [15:0] init_try_limit;
    logic [3:0]  voltage_code;
    logic [7:0]  check_pattern;
    logic [7:0]  host_capacity_byte;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  command_step;
    logic [7:0]  byte_index;
    logic [7:0]  poll_count;
    logic [15:0] attempts_left;
    logic [6:0]  crc_register;
    logic [7:0]  last_status_byte;
    logic [7:0]  resp_first;
    logic [7:0]  resp_last;
    logic        capacity_flag;
    logic [2:0]  outcome;
  } state_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       send_valid;
    logic       select_active;
    logic       finished;
    logic [2:0] result_code;
    logic       block_addressing;
  } result_t;

  function automatic logic [6:0] crc7_update(logic [6:0] crc, logic [7:0] data);
    logic [6:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[6] ^ data[i];
      c  = {c[5:0], 1'b0};
      if (fb) begin
        c = c ^ CRC7_POLY;
      end
    end
    return c;
  endfunction

  function automatic logic [5:0] cmd_index(logic [2:0] step);
    logic [5:0] idx;
    unique case (step)
      STEP_CMD0:   idx = 6'd0;
      STEP_CMD8:   idx = 6'd8;
      STEP_CMD55:  idx = 6'd55;
      STEP_ACMD41: idx = 6'd41;
      STEP_CMD58:  idx = 6'd58;
      STEP_CMD16:  idx = 6'd16;
      default:     idx = 6'd0;
    endcase
    return idx;
  endfunction

  function automatic logic [7:0] cmd_byte(cfg_t cfg, logic [2:0] step, logic [7:0] pos,
                                          logic [6:0] crc);
    logic [7:0] b;
    if (pos == '0) begin
      b = CMD_START_BITS | {2'b00, cmd_index(step)};
    end else if (pos >= CMD_CRC_POS) begin
      b = {crc, 1'b1};
    end else if (step == STEP_CMD8 && pos == ARG_POS_THREE) begin
      b = {4'b0000, cfg.voltage_code};
    end else if (step == STEP_CMD8 && pos == ARG_POS_FOUR) begin
      b = cfg.check_pattern;
    end else if (step == STEP_ACMD41 && pos == ARG_POS_ONE) begin
      b = cfg.host_capacity_byte;
    end else if (step == STEP_CMD16 && pos == ARG_POS_THREE) begin
      b = CMD16_ARG_BYTE;
    end else begin
      b = '0;
    end
    return b;
  endfunction

endpackage

@@ design/sd_card_spi_init_sequencer.sv @@
// Top level of the SD card SPI-mode start-up sequencer with output register.
// The result of each input transfer is registered in the output register when that transfer is accepted.
// Throughput: one input transfer per cycle while in_stall is low; in_stall rises only while a held result
// is stalled by the consumer, set by the single output register.
// Reset (rst, synchronous): phase idle, state cleared, registers to their defaults.
`include "assert_macros.svh"

module sd_card_spi_init_sequencer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [sdinit_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sdinit_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               command,
  input  logic [7:0]                         rx_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         tx_byte,
  output logic                               send_valid,
  output logic                               select_active,
  output logic                               finished,
  output logic [2:0]                         result_code,
  output logic                               block_addressing
);

  sdinit_pkg::cfg_t    cfg;
  sdinit_pkg::state_t  st;
  sdinit_pkg::state_t  st_next;
  sdinit_pkg::result_t res;
  sdinit_pkg::result_t res_next;
  logic                accept;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dummy_byte_count   <= sdinit_pkg::RST_DUMMY_BYTE_COUNT;
      cfg.response_tries     <= sdinit_pkg::RST_RESPONSE_TRIES;
      cfg.init_try_limit     <= sdinit_pkg::RST_INIT_TRY_LIMIT;
      cfg.voltage_code       <= sdinit_pkg::RST_VOLTAGE_CODE;
      cfg.check_pattern      <= sdinit_pkg::RST_CHECK_PATTERN;
      cfg.host_capacity_byte <= sdinit_pkg::RST_HOST_CAPACITY_BYTE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdinit_pkg::REG_DUMMY_BYTE_COUNT:   cfg.dummy_byte_count   <= cfg_data[7:0];
        sdinit_pkg::REG_RESPONSE_TRIES:     cfg.response_tries     <= cfg_data[7:0];
        sdinit_pkg::REG_INIT_TRY_LIMIT:     cfg.init_try_limit     <= cfg_data[15:0];
        sdinit_pkg::REG_VOLTAGE_CODE:       cfg.voltage_code       <= cfg_data[3:0];
        sdinit_pkg::REG_CHECK_PATTERN:      cfg.check_pattern      <= cfg_data[7:0];
        sdinit_pkg::REG_HOST_CAPACITY_BYTE: cfg.host_capacity_byte <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  sdinit_next u_next (
    .cfg     (cfg),
    .cur     (st),
    .command (command),
    .rx_byte (rx_byte),
    .nxt     (st_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase            <= sdinit_pkg::PH_IDLE;
      st.command_step     <= '0;
      st.byte_index       <= '0;
      st.poll_count       <= '0;
      st.attempts_left    <= '0;
      st.crc_register     <= '0;
      st.last_status_byte <= '0;
      st.resp_first       <= '0;
      st.resp_last        <= '0;
      st.capacity_flag    <= 1'b0;
      st.outcome          <= sdinit_pkg::RC_RUN;
      out_valid           <= 1'b0;
    end else if (accept) begin
      st        <= st_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign tx_byte          = res.tx_byte;
  assign send_valid       = res.send_valid;
  assign select_active    = res.select_active;
  assign finished         = res.finished;
  assign result_code      = res.result_code;
  assign block_addressing = res.block_addressing;

  `SDI_ASSERT_IMPLY(a_finished_quiet, clk, rst, out_valid && finished, !send_valid && !select_active)
  `SDI_ASSERT_IMPLY(a_code_ends, clk, rst, out_valid && (result_code != sdinit_pkg::RC_RUN), finished)
  `SDI_ASSERT_IMPLY(a_capacity_ok, clk, rst, out_valid && block_addressing, result_code == sdinit_pkg::RC_OK)
  `SDI_ASSERT_NEXT(a_start_runs, clk, rst, in_valid && !in_stall && !command, out_valid && !finished && (result_code == sdinit_pkg::RC_RUN))

endmodule

@@ design/sdinit_next.sv @@
// Next-state and next-byte logic for one SPI byte transfer of the start-up sequence.
module sdinit_next (
  input  sdinit_pkg::cfg_t    cfg,
  input  sdinit_pkg::state_t  cur,
  input  logic                command,
  input  logic [7:0]          rx_byte,
  output sdinit_pkg::state_t  nxt,
  output sdinit_pkg::result_t res
);

  function automatic sdinit_pkg::state_t start_cmd(sdinit_pkg::state_t s, logic [2:0] step);
    sdinit_pkg::state_t r;
    r              = s;
    r.command_step = step;
    r.byte_index   = '0;
    r.crc_register = '0;
    r.phase        = sdinit_pkg::PH_CMD;
    return r;
  endfunction

  function automatic sdinit_pkg::state_t finish(sdinit_pkg::state_t s, logic [2:0] code);
    sdinit_pkg::state_t r;
    r         = s;
    r.outcome = code;
    r.phase   = sdinit_pkg::PH_DONE;
    return r;
  endfunction

  logic [7:0]  tries;
  logic [7:0]  bi_inc;
  logic [7:0]  poll_inc;
  logic [15:0] att_dec;

  always_comb begin
    tries    = (cfg.response_tries == '0) ? 8'd1 : cfg.response_tries;
    bi_inc   = cur.byte_index + 8'd1;
    poll_inc = cur.poll_count + 8'd1;
    att_dec  = (cur.attempts_left != '0) ? cur.attempts_left - 16'd1 : '0;

    nxt = cur;
    if (!command) begin
      nxt.outcome          = sdinit_pkg::RC_RUN;
      nxt.capacity_flag    = 1'b0;
      nxt.last_status_byte = '0;
      nxt.poll_count       = '0;
      nxt.attempts_left    = '0;
      nxt.resp_first       = '0;
      nxt.resp_last        = '0;
      nxt.byte_index       = '0;
      if (cfg.dummy_byte_count != '0) begin
        nxt.phase = sdinit_pkg::PH_DUMMY;
      end else begin
        nxt = start_cmd(nxt, sdinit_pkg::STEP_CMD0);
      end
    end else begin
      unique case (cur.phase)
        sdinit_pkg::PH_DUMMY: begin
          nxt.byte_index = bi_inc;
          if (bi_inc >= cfg.dummy_byte_count) begin
            nxt = start_cmd(nxt, sdinit_pkg::STEP_CMD0);
          end
        end
        sdinit_pkg::PH_CMD: begin
          if (cur.byte_index < sdinit_pkg::CMD_CRC_POS) begin
            nxt.crc_register = sdinit_pkg::crc7_update(cur.crc_register,
              sdinit_pkg::cmd_byte(cfg, cur.command_step, cur.byte_index, cur.crc_register));
          end
          nxt.byte_index = bi_inc;
          if (bi_inc >= sdinit_pkg::CMD_LENGTH) begin
            nxt.phase      = sdinit_pkg::PH_WAIT;
            nxt.poll_count = '0;
          end
        end
        sdinit_pkg::PH_WAIT: begin
          nxt.last_status_byte = rx_byte;
          nxt.poll_count       = poll_inc;
          if (!rx_byte[sdinit_pkg::R1_BUSY_BIT] || poll_inc >= tries) begin
            if (cur.command_step == sdinit_pkg::STEP_CMD8 ||
                cur.command_step == sdinit_pkg::STEP_CMD58) begin
              nxt.phase      = sdinit_pkg::PH_DATA;
              nxt.byte_index = '0;
            end else begin
              nxt.phase = sdinit_pkg::PH_RELEASE;
            end
          end
        end
        sdinit_pkg::PH_DATA: begin
          if (cur.byte_index[1:0] == sdinit_pkg::DATA_FIRST) begin
            nxt.resp_first = rx_byte;
          end
          if (cur.byte_index[1:0] == sdinit_pkg::DATA_LAST) begin
            nxt.resp_last = rx_byte;
          end
          nxt.byte_index = bi_inc;
          if (bi_inc >= sdinit_pkg::DATA_LENGTH) begin
            nxt.phase = sdinit_pkg::PH_RELEASE;
          end
        end
        sdinit_pkg::PH_RELEASE: begin
          unique case (cur.command_step)
            sdinit_pkg::STEP_CMD0: begin
              if (cur.last_status_byte != sdinit_pkg::R1_IDLE_VALUE) begin
                nxt = finish(nxt, sdinit_pkg::RC_NO_CARD);
              end else begin
                nxt = start_cmd(nxt, sdinit_pkg::STEP_CMD8);
              end
            end
            sdinit_pkg::STEP_CMD8: begin
              if (cur.last_status_byte[sdinit_pkg::R1_ILLEGAL_BIT]) begin
                nxt = finish(nxt, sdinit_pkg::RC_V1_CARD);
              end else if (cur.resp_last != cfg.check_pattern) begin
                nxt = finish(nxt, sdinit_pkg::RC_ECHO);
              end else begin
                nxt.attempts_left = (cfg.init_try_limit == '0) ? 16'd1 : cfg.init_try_limit;
                nxt = start_cmd(nxt, sdinit_pkg::STEP_CMD55);
              end
            end
            sdinit_pkg::STEP_CMD55, sdinit_pkg::STEP_ACMD41: begin
              if (cur.command_step == sdinit_pkg::STEP_CMD55 &&
                  !cur.last_status_byte[sdinit_pkg::R1_ILLEGAL_BIT]) begin
                nxt = start_cmd(nxt, sdinit_pkg::STEP_ACMD41);
              end else begin
                // close one ACMD41 attempt
                nxt.attempts_left = att_dec;
                if (!cur.last_status_byte[sdinit_pkg::R1_IDLE_BIT]) begin
                  nxt = start_cmd(nxt, sdinit_pkg::STEP_CMD58);
                end else if (att_dec == '0) begin
                  nxt = finish(nxt, sdinit_pkg::RC_TIMEOUT);
                end else begin
                  nxt = start_cmd(nxt, sdinit_pkg::STEP_CMD55);
                end
              end
            end
            sdinit_pkg::STEP_CMD58: begin
              if (!cur.resp_first[sdinit_pkg::OCR_READY_BIT]) begin
                nxt = finish(nxt, sdinit_pkg::RC_NOT_READY);
              end else begin
                nxt.capacity_flag = cur.resp_first[sdinit_pkg::OCR_CCS_BIT];
                if (cur.resp_first[sdinit_pkg::OCR_CCS_BIT]) begin
                  nxt = finish(nxt, sdinit_pkg::RC_OK);
                end else begin
                  nxt = start_cmd(nxt, sdinit_pkg::STEP_CMD16);
                end
              end
            end
            default: begin
              nxt = finish(nxt, sdinit_pkg::RC_OK);
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    res.tx_byte          = '0;
    res.send_valid       = 1'b0;
    res.select_active    = 1'b0;
    res.finished         = 1'b0;
    res.result_code      = nxt.outcome;
    res.block_addressing = nxt.capacity_flag;
    unique case (nxt.phase)
      sdinit_pkg::PH_DUMMY, sdinit_pkg::PH_RELEASE: begin
        res.tx_byte    = sdinit_pkg::IDLE_BYTE;
        res.send_valid = 1'b1;
      end
      sdinit_pkg::PH_CMD: begin
        res.tx_byte       = sdinit_pkg::cmd_byte(cfg, nxt.command_step, nxt.byte_index,
                                                 nxt.crc_register);
        res.send_valid    = 1'b1;
        res.select_active = 1'b1;
      end
      sdinit_pkg::PH_WAIT, sdinit_pkg::PH_DATA: begin
        res.tx_byte       = sdinit_pkg::IDLE_BYTE;
        res.send_valid    = 1'b1;
        res.select_active = 1'b1;
      end
      sdinit_pkg::PH_DONE: begin
        res.finished = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ verif/tb.sv @@
// Self-checking bench for the SD card SPI start-up sequencer: scripted start-up plus card sessions.
module tb;

  typedef enum int {
    SC_SDHC, SC_SDSC, SC_NO_CARD, SC_V1, SC_ECHO_BAD,
    SC_TIMEOUT, SC_NOT_READY, SC_CMD55_REJECT, SC_LAST_TRY
  } card_kind_t;

  typedef struct {
    bit                  cmd;
    logic [7:0]          rx;
    bit                  typed;
    sdinit_pkg::result_t want;
  } script_row_t;

  localparam sdinit_pkg::result_t QUIET       = '0;
  localparam sdinit_pkg::result_t CLOCKING    =
    {sdinit_pkg::IDLE_BYTE, 1'b1, 1'b0, 1'b0, sdinit_pkg::RC_RUN, 1'b0};
  localparam sdinit_pkg::result_t CMD0_HEAD   =
    {8'h40, 1'b1, 1'b1, 1'b0, sdinit_pkg::RC_RUN, 1'b0};
  localparam sdinit_pkg::result_t CMD0_CRC    =
    {8'h95, 1'b1, 1'b1, 1'b0, sdinit_pkg::RC_RUN, 1'b0};
  localparam sdinit_pkg::result_t NO_CARD_END =
    {8'h00, 1'b0, 1'b0, 1'b1, sdinit_pkg::RC_NO_CARD, 1'b0};

  logic                               clk;
  logic                               rst;
  logic                               cfg_we;
  logic [sdinit_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [sdinit_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                               in_valid;
  logic                               in_stall;
  logic                               command;
  logic [7:0]                         rx_byte;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [7:0]                         tx_byte;
  logic                               send_valid;
  logic                               select_active;
  logic                               finished;
  logic [2:0]                         result_code;
  logic                               block_addressing;

  sd_card_spi_init_sequencer dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .tx_byte(tx_byte), .send_valid(send_valid), .select_active(select_active),
    .finished(finished), .result_code(result_code), .block_addressing(block_addressing)
  );

  // shadow of the sequencer
  sdinit_pkg::cfg_t   cfg;
  sdinit_pkg::phase_t m_phase;
  logic [2:0]         m_step;
  logic [7:0]         m_idx;
  logic [7:0]         m_polls;
  logic [15:0]        m_tries_left;
  logic [6:0]         m_crc;
  logic [7:0]         m_status;
  logic [7:0]         m_resp [4];
  logic               m_ccs;
  logic [2:0]         m_outcome;

  sdinit_pkg::result_t answers_due [$];
  sdinit_pkg::result_t seen;
  sdinit_pkg::result_t owed;

  card_kind_t card_kind;
  int acmd_seen;
  int cmd55_seen;
  int leave_at;

  int n_fail;
  int n_checked;
  int n_live;
  int n_writes;
  int burst_left;
  int stall_tick = 0;
  int stall_mode = 0;
  int endings [8];

  script_row_t script [24] = '{
    '{1'b1, 8'h00, 1'b1, QUIET},
    '{1'b0, 8'hFF, 1'b1, CLOCKING},
    '{1'b1, 8'h55, 1'b1, CMD0_HEAD},
    '{1'b1, 8'hAA, 1'b0, QUIET},
    '{1'b1, 8'h00, 1'b0, QUIET},
    '{1'b1, 8'hFF, 1'b0, QUIET},
    '{1'b1, 8'h80, 1'b0, QUIET},
    '{1'b1, 8'h7F, 1'b1, CMD0_CRC},
    '{1'b1, 8'h00, 1'b0, QUIET},
    '{1'b1, 8'hFF, 1'b0, QUIET},
    '{1'b1, 8'h01, 1'b1, NO_CARD_END},
    '{1'b1, 8'h01, 1'b1, NO_CARD_END},
    '{1'b0, 8'h00, 1'b1, CLOCKING},
    '{1'b1, 8'hFF, 1'b1, CMD0_HEAD},
    '{1'b1, 8'h0F, 1'b0, QUIET},
    '{1'b1, 8'hF0, 1'b0, QUIET},
    '{1'b1, 8'h33, 1'b0, QUIET},
    '{1'b1, 8'hCC, 1'b0, QUIET},
    '{1'b1, 8'h00, 1'b1, CMD0_CRC},
    '{1'b1, 8'h00, 1'b0, QUIET},
    '{1'b1, 8'h01, 1'b0, QUIET},
    '{1'b1, 8'hFF, 1'b0, QUIET},
    '{1'b0, 8'hAA, 1'b1, CLOCKING},
    '{1'b1, 8'h80, 1'b0, QUIET}
  };

  function automatic logic [6:0] crc7_step(logic [6:0] crc, logic [7:0] b);
    logic [6:0] r;
    logic       fb;
    r = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[6] ^ b[k];
      r  = {r[5:3], r[2] ^ fb, r[1:0], fb};
    end
    return r;
  endfunction

  function automatic logic [7:0] frame_byte(logic [2:0] stp, logic [7:0] pos);
    logic [5:0] opc;
    logic [7:0] b;
    case (stp)
      sdinit_pkg::STEP_CMD8:   opc = 6'd8;
      sdinit_pkg::STEP_CMD55:  opc = 6'd55;
      sdinit_pkg::STEP_ACMD41: opc = 6'd41;
      sdinit_pkg::STEP_CMD58:  opc = 6'd58;
      sdinit_pkg::STEP_CMD16:  opc = 6'd16;
      default:                 opc = 6'd0;
    endcase
    b = 8'h00;
    if (pos == 8'd0) begin
      b = {2'b01, opc};
    end else if (pos >= sdinit_pkg::CMD_CRC_POS) begin
      b = {m_crc, 1'b1};
    end else if (stp == sdinit_pkg::STEP_CMD8 && pos == sdinit_pkg::ARG_POS_THREE) begin
      b = {4'h0, cfg.voltage_code};
    end else if (stp == sdinit_pkg::STEP_CMD8 && pos == sdinit_pkg::ARG_POS_FOUR) begin
      b = cfg.check_pattern;
    end else if (stp == sdinit_pkg::STEP_ACMD41 && pos == sdinit_pkg::ARG_POS_ONE) begin
      b = cfg.host_capacity_byte;
    end else if (stp == sdinit_pkg::STEP_CMD16 && pos == sdinit_pkg::ARG_POS_THREE) begin
      b = sdinit_pkg::CMD16_ARG_BYTE;
    end
    return b;
  endfunction

  function automatic void begin_frame(logic [2:0] stp);
    m_step  = stp;
    m_idx   = '0;
    m_crc   = '0;
    m_phase = sdinit_pkg::PH_CMD;
  endfunction

  function automatic void end_seq(logic [2:0] code);
    m_outcome = code;
    m_phase   = sdinit_pkg::PH_DONE;
  endfunction

  function automatic void close_attempt();
    if (m_tries_left != 16'd0) m_tries_left--;
    if (!m_status[sdinit_pkg::R1_IDLE_BIT]) begin
      begin_frame(sdinit_pkg::STEP_CMD58);
    end else if (m_tries_left == 16'd0) begin
      end_seq(sdinit_pkg::RC_TIMEOUT);
    end else begin
      begin_frame(sdinit_pkg::STEP_CMD55);
    end
  endfunction

  function automatic void judge_reply();
    case (m_step)
      sdinit_pkg::STEP_CMD0: begin
        if (m_status != sdinit_pkg::R1_IDLE_VALUE) end_seq(sdinit_pkg::RC_NO_CARD);
        else begin_frame(sdinit_pkg::STEP_CMD8);
      end
      sdinit_pkg::STEP_CMD8: begin
        if (m_status[sdinit_pkg::R1_ILLEGAL_BIT]) begin
          end_seq(sdinit_pkg::RC_V1_CARD);
        end else if (m_resp[3] != cfg.check_pattern) begin
          end_seq(sdinit_pkg::RC_ECHO);
        end else begin
          m_tries_left = (cfg.init_try_limit == 16'd0) ? 16'd1 : cfg.init_try_limit;
          begin_frame(sdinit_pkg::STEP_CMD55);
        end
      end
      sdinit_pkg::STEP_CMD55: begin
        if (m_status[sdinit_pkg::R1_ILLEGAL_BIT]) close_attempt();
        else begin_frame(sdinit_pkg::STEP_ACMD41);
      end
      sdinit_pkg::STEP_ACMD41: close_attempt();
      sdinit_pkg::STEP_CMD58: begin
        if (!m_resp[0][sdinit_pkg::OCR_READY_BIT]) begin
          end_seq(sdinit_pkg::RC_NOT_READY);
        end else begin
          m_ccs = m_resp[0][sdinit_pkg::OCR_CCS_BIT];
          if (m_ccs) end_seq(sdinit_pkg::RC_OK);
          else begin_frame(sdinit_pkg::STEP_CMD16);
        end
      end
      default: end_seq(sdinit_pkg::RC_OK);
    endcase
  endfunction

  function automatic void advance_byte(logic [7:0] rx);
    int lim;
    lim = (cfg.response_tries == 8'd0) ? 1 : int'(cfg.response_tries);
    case (m_phase)
      sdinit_pkg::PH_DUMMY: begin
        m_idx++;
        if (m_idx >= cfg.dummy_byte_count) begin_frame(sdinit_pkg::STEP_CMD0);
      end
      sdinit_pkg::PH_CMD: begin
        if (m_idx < sdinit_pkg::CMD_CRC_POS) m_crc = crc7_step(m_crc, frame_byte(m_step, m_idx));
        m_idx++;
        if (m_idx >= sdinit_pkg::CMD_LENGTH) begin
          m_phase = sdinit_pkg::PH_WAIT;
          m_polls = '0;
        end
      end
      sdinit_pkg::PH_WAIT: begin
        m_status = rx;
        m_polls++;
        if (!rx[sdinit_pkg::R1_BUSY_BIT] || int'(m_polls) >= lim) begin
          if (m_step == sdinit_pkg::STEP_CMD8 || m_step == sdinit_pkg::STEP_CMD58) begin
            m_phase = sdinit_pkg::PH_DATA;
            m_idx   = '0;
          end else begin
            m_phase = sdinit_pkg::PH_RELEASE;
          end
        end
      end
      sdinit_pkg::PH_DATA: begin
        m_resp[m_idx[1:0]] = rx;
        m_idx++;
        if (m_idx >= sdinit_pkg::DATA_LENGTH) m_phase = sdinit_pkg::PH_RELEASE;
      end
      sdinit_pkg::PH_RELEASE: judge_reply();
      default: ;
    endcase
  endfunction

  function automatic sdinit_pkg::result_t sequencer_step(bit cmd, logic [7:0] rx);
    sdinit_pkg::result_t r;
    if (!cmd) begin
      m_outcome    = sdinit_pkg::RC_RUN;
      m_ccs        = 1'b0;
      m_status     = '0;
      m_polls      = '0;
      m_tries_left = '0;
      foreach (m_resp[k]) m_resp[k] = '0;
      m_idx = '0;
      if (cfg.dummy_byte_count != 8'd0) m_phase = sdinit_pkg::PH_DUMMY;
      else begin_frame(sdinit_pkg::STEP_CMD0);
    end else if (m_phase != sdinit_pkg::PH_IDLE && m_phase != sdinit_pkg::PH_DONE) begin
      advance_byte(rx);
    end
    r = '0;
    case (m_phase)
      sdinit_pkg::PH_DUMMY, sdinit_pkg::PH_RELEASE: begin
        r.tx_byte    = sdinit_pkg::IDLE_BYTE;
        r.send_valid = 1'b1;
      end
      sdinit_pkg::PH_CMD: begin
        r.tx_byte       = frame_byte(m_step, m_idx);
        r.send_valid    = 1'b1;
        r.select_active = 1'b1;
      end
      sdinit_pkg::PH_WAIT, sdinit_pkg::PH_DATA: begin
        r.tx_byte       = sdinit_pkg::IDLE_BYTE;
        r.send_valid    = 1'b1;
        r.select_active = 1'b1;
      end
      sdinit_pkg::PH_DONE: r.finished = 1'b1;
      default: ;
    endcase
    r.result_code      = m_outcome;
    r.block_addressing = m_ccs;
    return r;
  endfunction

  function automatic void reset_shadow();
    cfg.dummy_byte_count   = sdinit_pkg::RST_DUMMY_BYTE_COUNT;
    cfg.response_tries     = sdinit_pkg::RST_RESPONSE_TRIES;
    cfg.init_try_limit     = sdinit_pkg::RST_INIT_TRY_LIMIT;
    cfg.voltage_code       = sdinit_pkg::RST_VOLTAGE_CODE;
    cfg.check_pattern      = sdinit_pkg::RST_CHECK_PATTERN;
    cfg.host_capacity_byte = sdinit_pkg::RST_HOST_CAPACITY_BYTE;
    m_phase      = sdinit_pkg::PH_IDLE;
    m_step       = '0;
    m_idx        = '0;
    m_polls      = '0;
    m_tries_left = '0;
    m_crc        = '0;
    m_status     = '0;
    foreach (m_resp[k]) m_resp[k] = '0;
    m_ccs     = 1'b0;
    m_outcome = sdinit_pkg::RC_RUN;
  endfunction

  // card side: answer the byte the sequencer is about to read
  function automatic logic [7:0] pick_rx();
    int         lim;
    logic [7:0] b;
    lim = (cfg.response_tries == 8'd0) ? 1 : int'(cfg.response_tries);
    b = 8'($urandom);
    if (m_phase == sdinit_pkg::PH_WAIT) begin
      if ($urandom_range(0, 39) == 0) begin
        b = 8'($urandom);
      end else if ($urandom_range(0, 2) == 0 &&
                   (int'(m_polls) + 1 < lim || $urandom_range(0, 9) == 0)) begin
        b = 8'h80 | 8'($urandom_range(0, 127));
      end else begin
        case (m_step)
          sdinit_pkg::STEP_CMD0: begin
            if (card_kind != SC_NO_CARD) b = sdinit_pkg::R1_IDLE_VALUE;
            else case ($urandom_range(0, 2))
              0:       b = 8'h00;
              1:       b = 8'h05;
              default: b = 8'hFF;
            endcase
          end
          sdinit_pkg::STEP_CMD8: b = (card_kind == SC_V1) ? 8'h05 : sdinit_pkg::R1_IDLE_VALUE;
          sdinit_pkg::STEP_CMD55: begin
            cmd55_seen++;
            if (card_kind == SC_CMD55_REJECT && cmd55_seen == 1)
              b = $urandom_range(0, 1) ? 8'h05 : 8'h04;
            else
              b = sdinit_pkg::R1_IDLE_VALUE;
          end
          sdinit_pkg::STEP_ACMD41: begin
            acmd_seen++;
            b = (acmd_seen >= leave_at) ? 8'h00 : sdinit_pkg::R1_IDLE_VALUE;
          end
          sdinit_pkg::STEP_CMD58: b = $urandom_range(0, 1) ? 8'h00 : sdinit_pkg::R1_IDLE_VALUE;
          default:                b = 8'h00;
        endcase
      end
    end else if (m_phase == sdinit_pkg::PH_DATA) begin
      if (m_step == sdinit_pkg::STEP_CMD8 && m_idx == 8'd3) begin
        b = cfg.check_pattern;
        if (card_kind == SC_ECHO_BAD) b = b ^ (8'h01 << $urandom_range(0, 7));
      end else if (m_step == sdinit_pkg::STEP_CMD58 && m_idx == 8'd0) begin
        b[sdinit_pkg::OCR_READY_BIT] = (card_kind != SC_NOT_READY);
        if (card_kind == SC_SDHC) b[sdinit_pkg::OCR_CCS_BIT] = 1'b1;
        if (card_kind == SC_SDSC) b[sdinit_pkg::OCR_CCS_BIT] = 1'b0;
      end
    end
    return b;
  endfunction

  task automatic report(string msg);
    if (n_fail < 40) $display("MISMATCH %s", msg);
    n_fail++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report($sformatf("transfer %0d: %s is %0h, want %0h", n_checked, name, got, want));
  endtask

  task automatic write_reg(logic [sdinit_pkg::CFG_INDEX_W-1:0] idx,
                           logic [sdinit_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      sdinit_pkg::REG_DUMMY_BYTE_COUNT:   cfg.dummy_byte_count   = val[7:0];
      sdinit_pkg::REG_RESPONSE_TRIES:     cfg.response_tries     = val[7:0];
      sdinit_pkg::REG_INIT_TRY_LIMIT:     cfg.init_try_limit     = val;
      sdinit_pkg::REG_VOLTAGE_CODE:       cfg.voltage_code       = val[3:0];
      sdinit_pkg::REG_CHECK_PATTERN:      cfg.check_pattern      = val[7:0];
      sdinit_pkg::REG_HOST_CAPACITY_BYTE: cfg.host_capacity_byte = val[7:0];
      default: ;
    endcase
    n_writes++;
    @(posedge clk);
  endtask

  task automatic offer(bit cmd, logic [7:0] rx, sdinit_pkg::result_t due);
    int gap;
    answers_due.push_back(due);
    @(negedge clk);
    in_valid <= 1'b1;
    command  <= cmd;
    rx_byte  <= rx;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) @(negedge clk) in_valid <= 1'b0;
      burst_left = $urandom_range(1, 30);
    end
  endtask

  task automatic card_item(bit cmd, logic [7:0] rx);
    sdinit_pkg::result_t r;
    if (!cmd || (m_phase != sdinit_pkg::PH_IDLE && m_phase != sdinit_pkg::PH_DONE)) n_live++;
    r = sequencer_step(cmd, rx);
    offer(cmd, rx, r);
  endtask

  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_tick % 5 < 2);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen = {tx_byte, send_valid, select_active, finished, result_code, block_addressing};
      if (answers_due.size() == 0) begin
        report($sformatf("transfer %0d: result with nothing pending", n_checked));
      end else begin
        owed = answers_due.pop_front();
        check_field("tx_byte", int'(seen.tx_byte), int'(owed.tx_byte));
        check_field("send_valid", int'(seen.send_valid), int'(owed.send_valid));
        check_field("select_active", int'(seen.select_active), int'(owed.select_active));
        check_field("finished", int'(seen.finished), int'(owed.finished));
        check_field("result_code", int'(seen.result_code), int'(owed.result_code));
        check_field("block_addressing", int'(seen.block_addressing),
                    int'(owed.block_addressing));
        n_checked++;
      end
    end
  end

  initial begin
    #2000000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    script_row_t         row;
    sdinit_pkg::result_t r;
    logic [15:0]         lim16;
    int                  seq_no;
    int                  cap;

    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    command    = 1'b0;
    rx_byte    = '0;
    burst_left = 8;
    reset_shadow();
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    write_reg(sdinit_pkg::REG_DUMMY_BYTE_COUNT, 16'd1);
    write_reg(sdinit_pkg::REG_RESPONSE_TRIES, 16'd0);
    write_reg(sdinit_pkg::REG_INIT_TRY_LIMIT, 16'd0);
    @(negedge clk) cfg_we <= 1'b0;
    for (int i = 0; i < 24; i++) begin
      row = script[i];
      r   = sequencer_step(row.cmd, row.rx);
      offer(row.cmd, row.rx, row.typed ? row.want : r);
    end

    seq_no = 0;
    while (n_live < 950) begin
      drain();
      card_kind = (seq_no < 9) ? card_kind_t'(seq_no) : card_kind_t'($urandom_range(0, 8));
      case (card_kind)
        SC_TIMEOUT: begin
          lim16    = 16'($urandom_range(0, 3));
          leave_at = 1000;
        end
        SC_LAST_TRY: begin
          lim16    = 16'($urandom_range(1, 4));
          leave_at = int'(lim16);
        end
        SC_CMD55_REJECT: begin
          lim16    = 16'($urandom_range(2, 5));
          leave_at = 1;
        end
        default: begin
          case ($urandom_range(0, 3))
            0:       lim16 = 16'd0;
            1:       lim16 = 16'hFFFF;
            default: lim16 = 16'($urandom_range(1, 6));
          endcase
          cap      = (lim16 == 16'd0) ? 1 : ((lim16 < 16'd3) ? int'(lim16) : 3);
          leave_at = $urandom_range(1, cap);
        end
      endcase
      if (seq_no == 2) write_reg(sdinit_pkg::REG_DUMMY_BYTE_COUNT, 16'd255);
      else if ($urandom_range(0, 9) == 0)
        write_reg(sdinit_pkg::REG_DUMMY_BYTE_COUNT, 16'($urandom_range(4, 20)));
      else write_reg(sdinit_pkg::REG_DUMMY_BYTE_COUNT, 16'($urandom_range(0, 3)));
      if (seq_no == 3 || $urandom_range(0, 9) == 0)
        write_reg(sdinit_pkg::REG_RESPONSE_TRIES, 16'd255);
      else write_reg(sdinit_pkg::REG_RESPONSE_TRIES, 16'($urandom_range(0, 4)));
      write_reg(sdinit_pkg::REG_INIT_TRY_LIMIT, lim16);
      write_reg(sdinit_pkg::REG_VOLTAGE_CODE, 16'($urandom_range(0, 15)));
      if ($urandom_range(0, 5) == 0)
        write_reg(sdinit_pkg::REG_CHECK_PATTERN, $urandom_range(0, 1) ? 16'h00FF : 16'h0000);
      else write_reg(sdinit_pkg::REG_CHECK_PATTERN, 16'($urandom_range(0, 255)));
      if ($urandom_range(0, 5) == 0)
        write_reg(sdinit_pkg::REG_HOST_CAPACITY_BYTE,
                  $urandom_range(0, 1) ? 16'h00FF : 16'h0000);
      else write_reg(sdinit_pkg::REG_HOST_CAPACITY_BYTE, 16'($urandom_range(0, 255)));
      @(negedge clk) cfg_we <= 1'b0;

      acmd_seen  = 0;
      cmd55_seen = 0;
      card_item(1'b0, 8'($urandom));
      while (m_phase != sdinit_pkg::PH_DONE) begin
        if ($urandom_range(0, 199) == 0) begin
          card_item(1'b0, 8'($urandom));
          acmd_seen  = 0;
          cmd55_seen = 0;
        end else begin
          card_item(1'b1, pick_rx());
        end
      end
      endings[m_outcome]++;
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) card_item(1'b1, 8'($urandom));
      seq_no++;
    end
    drain();

    $display("covered %0d card sessions, %0d results compared, %0d register writes",
             seq_no, n_checked, n_writes);
    $display("endings: ok %0d, no card %0d, v1 %0d, echo %0d, timeout %0d, not ready %0d",
             endings[sdinit_pkg::RC_OK], endings[sdinit_pkg::RC_NO_CARD],
             endings[sdinit_pkg::RC_V1_CARD], endings[sdinit_pkg::RC_ECHO],
             endings[sdinit_pkg::RC_TIMEOUT], endings[sdinit_pkg::RC_NOT_READY]);
    if (n_fail == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/sdinit_pkg.sv
design/sdinit_next.sv
design/sd_card_spi_init_sequencer.sv
verif/tb.sv
